[hdl/upd_pkg.sv]
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    localparam int unsigned CAP_W = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    localparam int unsigned GROUP_MAX = 3;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    typedef struct packed {
        logic [GROUP_MAX-1:0][7:0] bytes;
        logic [1:0]                n;
        logic                      last;
    } t_group;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b0;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.ok  = 1'b1;
            r.val = 4'(c - 8'h37);
        end
        return r;
    endfunction

endpackage

[hdl/upd_ifs.sv]
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source(output valid, in_byte, in_last, input ready);
    modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_end;
    logic       out_status;
    modport source(output valid, out_byte, out_has_byte, out_end, out_status, input ready);
    modport sink(input valid, out_byte, out_has_byte, out_end, out_status, output ready);
endinterface

interface upd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_capacity;
    modport source(output valid, out_capacity, input ready);
    modport sink(input valid, out_capacity, output ready);
endinterface

[hdl/upd_front.sv]
module upd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    upd_in_if.sink            i_in,
    input  logic              i_full,
    output logic              o_push,
    output upd_pkg::t_group   o_group
);

    upd_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_held_digit, n_held_digit;
    logic [7:0]      r_held_char, n_held_char;

    upd_pkg::t_hex   hx;
    upd_pkg::t_group grp;
    logic            accept;
    logic            starts;

    always_comb begin
        hx           = upd_pkg::hex_decode(i_in.in_byte);
        starts       = (i_in.in_byte == upd_pkg::PCT_CHAR) && !i_in.in_last;
        n_phase      = upd_pkg::PH_PLAIN;
        n_held_digit = r_held_digit;
        n_held_char  = r_held_char;
        grp          = '0;
        grp.last     = i_in.in_last;

        unique case (r_phase)
            upd_pkg::PH_PCT: begin
                if (hx.ok && !i_in.in_last) begin
                    n_phase      = upd_pkg::PH_DIGIT;
                    n_held_digit = hx.val;
                    n_held_char  = i_in.in_byte;
                end else if (hx.ok) begin
                    grp.bytes[0] = upd_pkg::PCT_CHAR;
                    grp.bytes[1] = i_in.in_byte;
                    grp.n        = 2'd2;
                end else begin
                    grp.bytes[0] = upd_pkg::PCT_CHAR;
                    if (starts) begin
                        n_phase = upd_pkg::PH_PCT;
                        grp.n   = 2'd1;
                    end else begin
                        grp.bytes[1] = i_in.in_byte;
                        grp.n        = 2'd2;
                    end
                end
            end
            upd_pkg::PH_DIGIT: begin
                if (hx.ok) begin
                    grp.bytes[0] = {r_held_digit, hx.val};
                    grp.n        = 2'd1;
                end else begin
                    grp.bytes[0] = upd_pkg::PCT_CHAR;
                    grp.bytes[1] = r_held_char;
                    if (starts) begin
                        n_phase = upd_pkg::PH_PCT;
                        grp.n   = 2'd2;
                    end else begin
                        grp.bytes[2] = i_in.in_byte;
                        grp.n        = 2'd3;
                    end
                end
            end
            default: begin
                if (starts) begin
                    n_phase = upd_pkg::PH_PCT;
                end else begin
                    grp.bytes[0] = i_in.in_byte;
                    grp.n        = 2'd1;
                end
            end
        endcase

        if (i_in.in_last) begin
            n_phase      = upd_pkg::PH_PLAIN;
            n_held_digit = 4'd0;
            n_held_char  = 8'd0;
        end
    end

    assign accept     = i_in.valid && !i_full;
    assign i_in.ready = !i_full;
    assign o_push     = accept && ((grp.n != 2'd0) || grp.last);
    assign o_group    = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= upd_pkg::PH_PLAIN;
            r_held_digit <= 4'd0;
            r_held_char  <= 8'd0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_held_digit <= n_held_digit;
            r_held_char  <= n_held_char;
        end
    end

endmodule

[hdl/upd_queue.sv]
module upd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  upd_pkg::t_group   i_group,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_avail,
    output upd_pkg::t_group   o_head
);

    upd_pkg::t_group                     r_slots [upd_pkg::QUEUE_DEPTH];
    logic [upd_pkg::QPTR_W-1:0]          r_wr_ptr;
    logic [upd_pkg::QPTR_W-1:0]          r_rd_ptr;
    logic [upd_pkg::QCNT_W-1:0]          r_count;

    assign o_full  = (r_count == upd_pkg::QCNT_W'(upd_pkg::QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/upd_back.sv]
module upd_back #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  upd_pkg::t_group   i_head,
    output logic              o_pop,
    upd_cfg_if.sink           i_cfg,
    upd_out_if.source         o_out
);

    localparam int unsigned CMP_W =
        (COUNT_BITS > upd_pkg::CAP_W) ? COUNT_BITS : upd_pkg::CAP_W;

    logic [upd_pkg::CAP_W-1:0] r_cap;
    logic [1:0]                r_idx, n_idx;
    logic [COUNT_BITS-1:0]     r_cnt, n_cnt;
    logic                      r_ovf, n_ovf;

    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_has_byte;
    logic                      r_out_end;
    logic                      r_out_status;

    logic                      adv;
    logic                      at_mark;
    logic                      is_final;
    logic                      drop;
    logic [7:0]                cur_byte;
    logic                      emit;
    logic [7:0]                e_byte;
    logic                      e_has_byte;
    logic                      e_end;
    logic                      e_status;

    always_comb begin
        adv      = i_avail && (!r_out_valid || o_out.ready);
        at_mark  = (r_idx == i_head.n);
        is_final = (r_idx == (i_head.n - 2'd1));
        drop     = r_ovf || (CMP_W'(r_cnt) >= CMP_W'(r_cap));

        unique case (r_idx)
            2'd0:    cur_byte = i_head.bytes[0];
            2'd1:    cur_byte = i_head.bytes[1];
            2'd2:    cur_byte = i_head.bytes[2];
            default: cur_byte = 8'd0;
        endcase

        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        o_pop      = 1'b0;
        emit       = 1'b0;
        e_byte     = 8'd0;
        e_has_byte = 1'b0;
        e_end      = 1'b0;
        e_status   = 1'b0;

        if (adv) begin
            if (at_mark) begin
                emit     = 1'b1;
                e_end    = 1'b1;
                e_status = r_ovf;
                o_pop    = 1'b1;
                n_idx    = 2'd0;
                n_cnt    = '0;
                n_ovf    = 1'b0;
            end else if (drop) begin
                n_ovf = 1'b1;
                if (is_final && !i_head.last) begin
                    o_pop = 1'b1;
                    n_idx = 2'd0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end else begin
                emit       = 1'b1;
                e_byte     = cur_byte;
                e_has_byte = 1'b1;
                e_end      = i_head.last && is_final;
                if (r_cnt != {COUNT_BITS{1'b1}}) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (is_final) begin
                    o_pop = 1'b1;
                    n_idx = 2'd0;
                    if (i_head.last) begin
                        n_cnt = '0;
                        n_ovf = 1'b0;
                    end
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
        end
    end

    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.out_has_byte = r_out_has_byte;
    assign o_out.out_end      = r_out_end;
    assign o_out.out_status   = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= upd_pkg::CAP_RESET;
            r_idx       <= 2'd0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cap <= i_cfg.out_capacity;
            end
            r_idx <= n_idx;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte     <= e_byte;
            r_out_has_byte <= e_has_byte;
            r_out_end      <= e_end;
            r_out_status   <= e_status;
        end
    end

endmodule

[hdl/uri_percent_decoder_unit.sv]
// Channel   Direction   Payload                                          Transfer
// i_in      in          in_byte[7:0], in_last                            valid & ready
// o_out     out         out_byte[7:0], out_has_byte, out_end, out_status valid & ready
// i_cfg     in          out_capacity[15:0]                               valid & ready
//
// An input byte yields zero to three output transfers.
// The output side emits one result per cycle while o_out.ready holds, so the sustained
// rate is one byte per cycle except when a byte releases two or three held bytes, which
// then pass the output register one after another; a four-entry queue absorbs those bursts.
// A byte dropped for overflow takes an output-side step without a transfer.
// Reset is synchronous and active low; capacity returns to 65535.
module uri_percent_decoder_unit #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    upd_in_if.sink      i_in,
    upd_out_if.source   o_out,
    upd_cfg_if.sink     i_cfg
);

    logic            push;
    logic            pop;
    logic            full;
    logic            avail;
    upd_pkg::t_group grp_in;
    upd_pkg::t_group grp_head;

    upd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_group (grp_in)
    );

    upd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (grp_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_head  (grp_head)
    );

    upd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_head  (grp_head),
        .o_pop   (pop),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

endmodule
